### hdl/cll_pkg.sv
package cll_pkg;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_LOCATE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISS    = 2'd3
   } status_type;

   typedef enum logic [13:0] {
      S_INIT   = 14'b00000000000001,
      S_IDLE   = 14'b00000000000010,
      S_INS_Q  = 14'b00000000000100,
      S_INS_QN = 14'b00000000001000,
      S_WALK   = 14'b00000000010000,
      S_TAIL   = 14'b00000000100000,
      S_DEL_QN = 14'b00000001000000,
      S_DEL_FH = 14'b00000010000000,
      S_RD_VAL = 14'b00000100000000,
      S_SCAN   = 14'b00001000000000,
      S_WR1    = 14'b00010000000000,
      S_WR2    = 14'b00100000000000,
      S_WR3    = 14'b01000000000000,
      S_DONE   = 14'b10000000000000
   } state_type;

   localparam int FREE_HEAD = 0;
   localparam int DATA_HEAD = 1;

endpackage

### hdl/cll_ram.sv
module cll_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/cursor_linked_list_engine_core.sv
// throughput: one command at a time; the walk follows one link per cycle through the
// single read port of the link memory
// reset: synchronous; afterwards a clearing pass rebuilds the free chain in the
// link memory, with req_ready low until it ends
module cursor_linked_list_engine_core #(
   parameter int NODE_COUNT  = 128,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cll_pkg::cmd_type          req_cmd,
   input  logic [6:0]                req_position,
   input  logic signed [31:0]        req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cll_pkg::status_type       rsp_status,
   output logic signed [31:0]        rsp_read_value,
   output logic [6:0]                rsp_found_position,
   output logic [6:0]                rsp_list_length
);

   import cll_pkg::*;

   localparam int AW = $clog2(NODE_COUNT);
   localparam int IW = $clog2(NODE_COUNT + 1);
   localparam int CW = ((AW > 7) ? AW : 7) + 2;
   localparam int VW = VALUE_WIDTH;

   function automatic logic [AW-1:0] next_of(input logic [AW-1:0] n);
      return (int'(n) < NODE_COUNT) ? n : '0;
   endfunction

   state_type        state_ff, state_in;
   cmd_type          cmd_ff, cmd_in;
   logic [6:0]       pos_ff, pos_in;
   logic [VW-1:0]    val_ff, val_in;
   logic [AW-1:0]    cur_ff, cur_in;
   logic [6:0]       steps_ff, steps_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    q_ff, q_in;
   logic [AW-1:0]    qn_ff, qn_in;
   logic [AW-1:0]    pn_ff, pn_in;
   logic [AW-1:0]    fh_ff, fh_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    len_ff, len_in;
   logic [AW-1:0]    init_ff, init_in;
   status_type       res_status_ff, res_status_in;
   logic [VW-1:0]    res_rd_ff, res_rd_in;
   logic [IW-1:0]    res_fpos_ff, res_fpos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_rd_ff, rsp_rd_in;
   logic [6:0]       rsp_fpos_ff, rsp_fpos_in;
   logic [6:0]       rsp_len_ff, rsp_len_in;

   logic             link_wr_en;
   logic [AW-1:0]    link_wr_addr;
   logic [AW-1:0]    link_wr_data;
   logic [AW-1:0]    link_rd_addr;
   logic [AW-1:0]    link_rd_data;
   logic             val_wr_en;
   logic [AW-1:0]    val_wr_addr;
   logic [VW-1:0]    val_wr_data;
   logic [AW-1:0]    val_rd_addr;
   logic [VW-1:0]    val_rd_data;

   logic [AW-1:0]    node_link;
   logic [AW-1:0]    walk_node;
   logic [CW-1:0]    pos_ext;
   logic [CW-1:0]    len_ext;
   logic             bad_ins;
   logic             bad_dr;
   logic [63:0]      val64;
   logic signed [63:0] rd64;
   logic [AW-1:0]    init_link;

   cll_ram #(.WIDTH(AW), .DEPTH(NODE_COUNT)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   cll_ram #(.WIDTH(VW), .DEPTH(NODE_COUNT)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   assign node_link = next_of(link_rd_data);
   assign walk_node = pend_ff ? node_link : cur_ff;
   assign pos_ext   = CW'(req_position);
   assign len_ext   = CW'(len_ff);
   assign bad_ins   = (req_position == 7'd0) || (pos_ext > len_ext + CW'(1));
   assign bad_dr    = (req_position == 7'd0) || (pos_ext > len_ext);
   assign val64     = 64'(req_value);
   assign rd64      = 64'($signed(res_rd_ff));

   // reset image of the link store: free chain from node 2, data list empty
   always_comb begin
      if (init_ff == AW'(FREE_HEAD)) begin
         init_link = AW'(2);
      end else if (init_ff == AW'(DATA_HEAD) || init_ff == AW'(NODE_COUNT - 1)) begin
         init_link = '0;
      end else begin
         init_link = init_ff + AW'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      pend_in       = pend_ff;
      q_in          = q_ff;
      qn_in         = qn_ff;
      pn_in         = pn_ff;
      fh_in         = fh_ff;
      idx_in        = idx_ff;
      len_in        = len_ff;
      init_in       = init_ff;
      res_status_in = res_status_ff;
      res_rd_in     = res_rd_ff;
      res_fpos_in   = res_fpos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rd_in     = rsp_rd_ff;
      rsp_fpos_in   = rsp_fpos_ff;
      rsp_len_in    = rsp_len_ff;
      link_wr_en    = 1'b0;
      link_wr_addr  = cur_ff;
      link_wr_data  = q_ff;
      link_rd_addr  = cur_ff;
      val_wr_en     = 1'b0;
      val_wr_addr   = q_ff;
      val_wr_data   = val_ff;
      val_rd_addr   = cur_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            link_wr_en   = 1'b1;
            link_wr_addr = init_ff;
            link_wr_data = init_link;
            init_in      = init_ff + AW'(1);
            if (init_ff == AW'(NODE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            link_rd_addr = (req_cmd == CMD_INSERT) ? AW'(FREE_HEAD) : AW'(DATA_HEAD);
            if (req_valid) begin
               cmd_in        = req_cmd;
               pos_in        = req_position;
               val_in        = val64[VW-1:0];
               cur_in        = AW'(DATA_HEAD);
               pend_in       = 1'b0;
               idx_in        = '0;
               res_status_in = ST_OK;
               res_rd_in     = '0;
               res_fpos_in   = '0;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (bad_ins) begin
                        res_status_in = ST_BAD_POS;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_INS_Q;
                     end
                  end
                  CMD_DELETE, CMD_READ: begin
                     steps_in = (req_cmd == CMD_READ) ? req_position
                                                      : req_position - 7'd1;
                     if (bad_dr) begin
                        res_status_in = ST_BAD_POS;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_INS_Q: begin
            if (node_link == '0) begin
               res_status_in = ST_FULL;
               state_in      = S_DONE;
            end else begin
               q_in         = node_link;
               link_rd_addr = node_link;
               state_in     = S_INS_QN;
            end
         end
         S_INS_QN: begin
            qn_in    = node_link;
            steps_in = pos_ff - 7'd1;
            state_in = S_WALK;
         end
         S_WALK: begin
            link_rd_addr = walk_node;
            val_rd_addr  = walk_node;
            cur_in       = walk_node;
            if (steps_ff == 7'd0) begin
               pend_in  = 1'b0;
               state_in = (cmd_ff == CMD_READ) ? S_RD_VAL : S_TAIL;
            end else begin
               pend_in  = 1'b1;
               steps_in = steps_ff - 7'd1;
            end
         end
         S_TAIL: begin
            if (cmd_ff == CMD_INSERT) begin
               pn_in    = node_link;
               state_in = S_WR1;
            end else begin
               q_in = node_link;
               if (node_link == '0) begin
                  state_in = S_DONE;
               end else begin
                  link_rd_addr = node_link;
                  state_in     = S_DEL_QN;
               end
            end
         end
         S_DEL_QN: begin
            qn_in        = node_link;
            link_rd_addr = AW'(FREE_HEAD);
            state_in     = S_DEL_FH;
         end
         S_DEL_FH: begin
            fh_in    = node_link;
            state_in = S_WR1;
         end
         S_RD_VAL: begin
            res_rd_in = val_rd_data;
            state_in  = S_DONE;
         end
         S_SCAN: begin
            link_rd_addr = node_link;
            val_rd_addr  = node_link;
            if (pend_ff && val_rd_data == val_ff) begin
               res_fpos_in = idx_ff;
               state_in    = S_DONE;
            end else if (node_link == '0 || idx_ff == IW'(NODE_COUNT)) begin
               res_status_in = ST_MISS;
               state_in      = S_DONE;
            end else begin
               pend_in = 1'b1;
               idx_in  = idx_ff + IW'(1);
            end
         end
         S_WR1: begin
            link_wr_en = 1'b1;
            if (cmd_ff == CMD_INSERT) begin
               link_wr_addr = AW'(FREE_HEAD);
               link_wr_data = qn_ff;
               val_wr_en    = 1'b1;
            end else begin
               link_wr_addr = cur_ff;
               link_wr_data = qn_ff;
            end
            state_in = S_WR2;
         end
         S_WR2: begin
            link_wr_en   = 1'b1;
            link_wr_addr = q_ff;
            link_wr_data = (cmd_ff == CMD_INSERT) ? pn_ff : fh_ff;
            state_in     = S_WR3;
         end
         S_WR3: begin
            link_wr_en   = 1'b1;
            link_wr_data = q_ff;
            if (cmd_ff == CMD_INSERT) begin
               link_wr_addr = cur_ff;
               len_in       = len_ff + AW'(1);
            end else begin
               link_wr_addr = AW'(FREE_HEAD);
               len_in       = len_ff - AW'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rd_in     = rd64[31:0];
               rsp_fpos_in   = 7'(res_fpos_ff);
               rsp_len_in    = 7'(len_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
            init_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_ff      <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      q_ff          <= q_in;
      qn_ff         <= qn_in;
      pn_ff         <= pn_in;
      fh_ff         <= fh_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_rd_ff     <= res_rd_in;
      res_fpos_ff   <= res_fpos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rd_ff     <= rsp_rd_in;
      rsp_fpos_ff   <= rsp_fpos_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_read_value     = rsp_rd_ff;
   assign rsp_found_position = rsp_fpos_ff;
   assign rsp_list_length    = rsp_len_ff;

   // no command taken while the free chain is being rebuilt
   a_init_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INIT |-> !req_ready)
      else $error("command accepted during clearing pass");

   // list never outgrows the store minus the two head nodes
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(len_ff) <= NODE_COUNT - 2)
      else $error("list length beyond store capacity");

   // head nodes never receive a data value
   a_val_addr: assert property (@(posedge clock) disable iff (reset)
      val_wr_en |-> (val_wr_addr != AW'(FREE_HEAD) && val_wr_addr != AW'(DATA_HEAD)))
      else $error("value written to a head node");

   // length moves by one, and only at the last link write of a command
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(len_ff) |-> $past(state_ff) == S_WR3)
      else $error("length changed outside link update");

endmodule

### tb/list_command_checker.sv
module list_command_checker #(
   parameter int NODE_COUNT = 128
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  cll_pkg::cmd_type     req_cmd,
   input  logic [6:0]           req_position,
   input  logic signed [31:0]   req_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  cll_pkg::status_type  rsp_status,
   input  logic signed [31:0]   rsp_read_value,
   input  logic [6:0]           rsp_found_position,
   input  logic [6:0]           rsp_list_length,
   output int                   mismatch_count,
   output int                   replies_pending
);

   import cll_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_value;
      logic [6:0]  found_position;
      logic [6:0]  list_length;
   } reply_type;

   logic [6:0]  next_node  [NODE_COUNT];
   logic [31:0] node_value [NODE_COUNT];
   int          node_total;
   reply_type   predicted_replies [$];

   task automatic clear_store();
      for (int i = 0; i < NODE_COUNT; i++) begin
         next_node[i]  = (i + 1 < NODE_COUNT) ? 7'(i + 1) : 7'd0;
         node_value[i] = '0;
      end
      next_node[FREE_HEAD] = 7'd2;
      next_node[DATA_HEAD] = 7'd0;
      node_total = 0;
   endtask

   // follow a number of links starting at the data head
   function automatic logic [6:0] node_at(input int steps);
      logic [6:0] node;
      node = 7'(DATA_HEAD);
      for (int k = 0; k < steps; k++) node = next_node[node];
      return node;
   endfunction

   function automatic reply_type apply_list_command(input cmd_type cmd,
                                                    input logic [6:0] position,
                                                    input logic [31:0] value);
      reply_type  r;
      logic [6:0] prev;
      logic [6:0] taken;
      logic [6:0] node;
      int         idx;
      r = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_INSERT: begin
            if (position == 0 || int'(position) > node_total + 1) begin
               r.status = ST_BAD_POS;
            end else if (next_node[FREE_HEAD] == 0) begin
               r.status = ST_FULL;
            end else begin
               taken = next_node[FREE_HEAD];
               prev  = node_at(int'(position) - 1);
               next_node[FREE_HEAD] = next_node[taken];
               node_value[taken]    = value;
               next_node[taken]     = next_node[prev];
               next_node[prev]      = taken;
               node_total++;
            end
         end
         CMD_DELETE: begin
            if (position == 0 || int'(position) > node_total) begin
               r.status = ST_BAD_POS;
            end else begin
               prev  = node_at(int'(position) - 1);
               taken = next_node[prev];
               if (taken != 0) begin
                  next_node[prev]      = next_node[taken];
                  next_node[taken]     = next_node[FREE_HEAD];
                  next_node[FREE_HEAD] = taken;
                  node_total--;
               end
            end
         end
         CMD_READ: begin
            if (position == 0 || int'(position) > node_total) begin
               r.status = ST_BAD_POS;
            end else begin
               r.read_value = node_value[node_at(int'(position))];
            end
         end
         default: begin
            r.status = ST_MISS;
            node = next_node[DATA_HEAD];
            idx  = 1;
            while (node != 0 && idx <= NODE_COUNT && r.status == ST_MISS) begin
               if (node_value[node] == value) begin
                  r.status         = ST_OK;
                  r.found_position = 7'(idx);
               end else begin
                  node = next_node[node];
                  idx++;
               end
            end
         end
      endcase
      r.list_length = 7'(node_total);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         clear_store();
         predicted_replies.delete();
      end else begin
         if (req_valid && req_ready) begin
            predicted_replies.push_back(apply_list_command(req_cmd, req_position, req_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               report_mismatch("result beat with nothing pending, status", 32'(rsp_status), 0);
            end else begin
               want = predicted_replies.pop_front();
               if (rsp_status != want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_read_value != want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (rsp_found_position != want.found_position)
                  report_mismatch("found_position", 32'(rsp_found_position),
                                  32'(want.found_position));
               if (rsp_list_length != want.list_length)
                  report_mismatch("list_length", 32'(rsp_list_length), 32'(want.list_length));
            end
         end
      end
      replies_pending <= predicted_replies.size();
   end

endmodule

### tb/cursor_linked_list_engine_core_tb.sv
module cursor_linked_list_engine_core_tb;

   import cll_pkg::*;

   localparam int NODES        = 128;
   localparam int MAX_LIST     = NODES - 2;
   localparam int TARGET_ITEMS = 1300;
   localparam int STALL_LIMIT  = 4000;
   localparam int LONG_HOLD    = 1000;
   localparam int DRAIN_CYCLES = 150;
   localparam int SENDER       = 0;
   localparam int RECEIVER     = 1;
   localparam int PHASE_GROW   = 0;
   localparam int PHASE_MIXED  = 1;
   localparam int PHASE_SHRINK = 2;

   logic               clock;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_ready;
   cmd_type            req_cmd      = CMD_INSERT;
   logic [6:0]         req_position = '0;
   logic signed [31:0] req_value    = '0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   status_type         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic [6:0]         rsp_found_position;
   logic [6:0]         rsp_list_length;

   int          mismatch_count;
   int          replies_pending;
   int          list_size;
   int          items_sent;
   int          replies_taken;
   int          idle_cycles;
   int          quiet_left [2];
   logic [31:0] value_pool [16];

   cursor_linked_list_engine_core #(
      .NODE_COUNT  (NODES),
      .VALUE_WIDTH (32)
   ) dut (.*);

   list_command_checker #(
      .NODE_COUNT (NODES)
   ) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle draw with occasional stretches of back-to-back beats
   function automatic int draw_gap(input int side);
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) quiet_left[side] = $urandom_range(10, 40);
      return $urandom_range(0, 11);
   endfunction

   task automatic send_command(input cmd_type cmd, input int position, input logic [31:0] value);
      int gap;
      gap = draw_gap(SENDER);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_position <= 7'(position);
      req_value    <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      case (cmd)
         CMD_INSERT: begin
            if (position >= 1 && position <= list_size + 1 && list_size < MAX_LIST) list_size++;
         end
         CMD_DELETE: begin
            if (position >= 1 && position <= list_size) list_size--;
         end
         default: ;
      endcase
      items_sent++;
   endtask

   task automatic send_random(input int phase);
      int          roll;
      int          position;
      cmd_type     cmd;
      logic [31:0] value;
      roll = $urandom_range(0, 99);
      case (phase)
         PHASE_GROW: begin
            cmd = roll < 55 ? CMD_INSERT : roll < 65 ? CMD_DELETE :
                  roll < 82 ? CMD_READ : CMD_LOCATE;
         end
         PHASE_SHRINK: begin
            cmd = roll < 10 ? CMD_INSERT : roll < 60 ? CMD_DELETE :
                  roll < 80 ? CMD_READ : CMD_LOCATE;
         end
         default: begin
            cmd = roll < 25 ? CMD_INSERT : roll < 50 ? CMD_DELETE :
                  roll < 75 ? CMD_READ : CMD_LOCATE;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         position = $urandom_range(0, 127);
      end else if (roll < 18) begin
         position = 1;
      end else if (cmd == CMD_INSERT) begin
         position = roll < 25 ? list_size + 1 : $urandom_range(1, list_size + 1);
      end else begin
         position = roll < 25 ? list_size : $urandom_range(1, list_size > 0 ? list_size : 1);
      end
      value = $urandom_range(0, 2) == 0 ? $urandom() : value_pool[$urandom_range(0, 15)];
      send_command(cmd, position, value);
   endtask

   initial begin
      int phase;
      int phase_left;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'h0000_0001;
      value_pool[2] = 32'hffff_ffff;
      value_pool[3] = 32'h7fff_ffff;
      value_pool[4] = 32'h8000_0000;
      for (int i = 5; i < 16; i++) value_pool[i] = $urandom();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty list corners, then a small list with duplicates
      send_command(CMD_READ,   1,   32'h0);
      send_command(CMD_DELETE, 1,   32'h0);
      send_command(CMD_LOCATE, 0,   32'h0);
      send_command(CMD_INSERT, 0,   32'h5);
      send_command(CMD_INSERT, 2,   32'h5);
      send_command(CMD_INSERT, 1,   32'h7fff_ffff);
      send_command(CMD_INSERT, 2,   32'h8000_0000);
      send_command(CMD_INSERT, 1,   32'hffff_ffff);
      send_command(CMD_INSERT, 4,   32'h0);
      send_command(CMD_INSERT, 3,   32'h8000_0000);
      send_command(CMD_READ,   1,   32'h0);
      send_command(CMD_READ,   5,   32'h0);
      send_command(CMD_READ,   6,   32'h0);
      send_command(CMD_READ,   0,   32'h0);
      send_command(CMD_LOCATE, 127, 32'h8000_0000);
      send_command(CMD_LOCATE, 0,   32'h1234_5678);
      send_command(CMD_LOCATE, 0,   32'h0);
      send_command(CMD_DELETE, 5,   32'h0);
      send_command(CMD_DELETE, 1,   32'h0);
      send_command(CMD_DELETE, 0,   32'h0);
      send_command(CMD_DELETE, 127, 32'h0);
      send_command(CMD_INSERT, 127, 32'hffff_ffff);
      send_command(CMD_READ,   127, 32'h0);
      send_command(CMD_LOCATE, 0,   32'h8000_0000);

      // grow to full, churn, shrink to empty, repeat
      phase      = PHASE_GROW;
      phase_left = -1;
      while (items_sent < TARGET_ITEMS) begin
         send_random(phase);
         if (phase_left > 0) begin
            phase_left--;
            if (phase_left == 0) begin
               phase      = (phase + 1) % 3;
               phase_left = (phase == PHASE_MIXED) ? 150 : -1;
            end
         end else if ((phase == PHASE_GROW && list_size == MAX_LIST) ||
                      (phase == PHASE_SHRINK && list_size == 0)) begin
            phase_left = 15;
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (replies_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cursor_linked_list_engine_core test passed");
      end else begin
         $display("cursor_linked_list_engine_core test failed");
      end
      $finish;
   end

   // result side, with one long hold-off so the block backs up
   initial begin
      int gap;
      forever begin
         gap = (replies_taken == 40) ? LONG_HOLD : draw_gap(RECEIVER);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         replies_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("cursor_linked_list_engine_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
